FILE: rtl/tmf_pkg.sv
// Shared types and constants for the five-sample trimmed-mean filter.
// Used by the channel interfaces and every tmf_* module; no dependencies.
package tmf_pkg;

  // Data sizes
  localparam int WINDOW       = 5;
  localparam int SAMPLE_BITS  = 10;
  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_BITS    = 3;
  localparam int CFG_BITS     = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

  // Window bookkeeping
  localparam int FILL_BITS = $clog2(WINDOW + 1);
  localparam int PASS_BITS = $clog2(WINDOW);
  localparam int MID       = WINDOW / 2;

  // Sum of the middle three and floor(sum / 3) by reciprocal multiply
  localparam int MEAN_COUNT  = 3;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int RECIP_SHIFT = SUM_BITS + 2;
  localparam int RECIP_BITS  = RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + MEAN_COUNT - 1) / MEAN_COUNT);
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef logic [CHAN_BITS-1:0]   chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_REJECT = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    chan_t     channel;
    sample_t   sample;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SORT = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_MEAN = 4'b1000
  } back_state_t;

endpackage

FILE: rtl/tmf_if.sv
// Valid/ready channel interfaces: sample input, command queue link, result output.
// Depends on tmf_pkg.
interface tmf_in_if;
  logic             valid;
  logic             ready;
  tmf_pkg::chan_t   channel;
  tmf_pkg::sample_t sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tmf_cmd_if;
  logic          valid;
  logic          ready;
  tmf_pkg::cmd_t cmd;

  modport source (output valid, output cmd, input ready);
  modport sink   (input valid, input cmd, output ready);
endinterface

interface tmf_out_if;
  logic             valid;
  logic             ready;
  tmf_pkg::chan_t   result_channel;
  tmf_pkg::sample_t filtered_value;
  logic             status;

  modport source (output valid, output result_channel, output filtered_value,
                  output status, input ready);
  modport sink   (input valid, input result_channel, input filtered_value,
                  input status, output ready);
endinterface

FILE: rtl/tmf_front.sv
// Front end: holds the channel-count register and classifies each sample
// as in range or rejected. Depends on tmf_pkg and tmf_if.
module tmf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tmf_pkg::CFG_BITS-1:0]    cfg_wdata,
  tmf_in_if.sink                          in_s,
  tmf_cmd_if.source                       cmd_s
);
  import tmf_pkg::*;

  logic [CFG_BITS-1:0] chan_count_r;
  logic                in_range;

  // channel-count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= CFG_RESET;
    end else if (cfg_we) begin
      chan_count_r <= cfg_wdata;
    end
  end

  // channel must be below both the programmed count and the hardware limit
  assign in_range = (CFG_BITS'(in_s.channel) < chan_count_r) &&
                    (int'(in_s.channel) < MAX_CHANNELS);

  // classify straight into the queue
  assign cmd_s.valid       = in_s.valid;
  assign cmd_s.cmd.kind    = in_range ? CMD_SAMPLE : CMD_REJECT;
  assign cmd_s.cmd.channel = in_s.channel;
  assign cmd_s.cmd.sample  = in_s.sample;
  assign in_s.ready        = cmd_s.ready;

endmodule

FILE: rtl/tmf_queue.sv
// Short command FIFO that decouples the front end from the back end.
// Depends on tmf_pkg and tmf_if.
module tmf_queue (
  input  logic      clk,
  input  logic      rst_n,
  tmf_cmd_if.sink   push_s,
  tmf_cmd_if.source pop_s
);
  import tmf_pkg::*;

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic                 push, pop;

  assign push_s.ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_s.valid  = (count_r != '0);
  assign pop_s.cmd    = mem_r[rd_ptr_r];
  assign push         = push_s.valid && push_s.ready;
  assign pop          = pop_s.valid && pop_s.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_s.cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/tmf_back.sv
// Back end: collects the window, sorts it by odd-even transposition,
// averages the middle three and drives the result register.
// Depends on tmf_pkg and tmf_if.
module tmf_back (
  input  logic      clk,
  input  logic      rst_n,
  tmf_cmd_if.sink   cmd_s,
  tmf_out_if.source out_s
);
  import tmf_pkg::*;

  back_state_t          state_r, state_nxt;
  sample_t              win_r [WINDOW];
  sample_t              win_nxt [WINDOW];
  logic [FILL_BITS-1:0] fill_r, fill_nxt, fill_eff;
  chan_t                win_ch_r, win_ch_nxt;
  logic [PASS_BITS-1:0] pass_r, pass_nxt;
  sum_t                 sum_r, sum_nxt;
  logic [PROD_BITS-1:0] product;

  logic                 out_valid_r, out_valid_nxt;
  chan_t                out_ch_r, out_ch_nxt;
  sample_t              out_val_r, out_val_nxt;
  logic                 out_st_r, out_st_nxt;
  logic                 out_free;
  logic                 pop;

  assign out_free = !out_valid_r || out_s.ready;
  assign product  = PROD_BITS'(sum_r) * PROD_BITS'(RECIP);

  // a new sample on another channel restarts the window
  assign fill_eff = ((fill_r != '0) && (cmd_s.cmd.channel != win_ch_r)) ? '0 : fill_r;

  assign cmd_s.ready = pop;

  // sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    win_ch_nxt    = win_ch_r;
    pass_nxt      = pass_r;
    sum_nxt       = sum_r;
    out_ch_nxt    = out_ch_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    pop           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_s.valid) begin
          if (cmd_s.cmd.kind == CMD_REJECT) begin
            // out-of-range request: answer at once, window untouched
            if (out_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              out_ch_nxt    = cmd_s.cmd.channel;
              out_val_nxt   = '0;
              out_st_nxt    = STATUS_RANGE;
            end
          end else begin
            pop        = 1'b1;
            win_ch_nxt = cmd_s.cmd.channel;
            for (int i = 0; i < WINDOW; i++) begin
              if (FILL_BITS'(i) == fill_eff) begin
                win_nxt[i] = cmd_s.cmd.sample;
              end
            end
            if (fill_eff == FILL_BITS'(WINDOW - 1)) begin
              fill_nxt  = '0;
              pass_nxt  = '0;
              state_nxt = ST_SORT;
            end else begin
              fill_nxt = fill_eff + 1'b1;
            end
          end
        end
      end

      ST_SORT: begin
        // one transposition pass: disjoint pairs, larger value first
        for (int i = 0; i < WINDOW - 1; i++) begin
          if (((i % 2) == int'(pass_r[0])) && (win_r[i] < win_r[i + 1])) begin
            win_nxt[i]     = win_r[i + 1];
            win_nxt[i + 1] = win_r[i];
          end
        end
        pass_nxt = pass_r + 1'b1;
        if (pass_r == PASS_BITS'(WINDOW - 1)) begin
          state_nxt = ST_SUM;
        end
      end

      ST_SUM: begin
        sum_nxt = SUM_BITS'(win_r[MID - 1]) + SUM_BITS'(win_r[MID]) +
                  SUM_BITS'(win_r[MID + 1]);
        state_nxt = ST_MEAN;
      end

      ST_MEAN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = win_ch_r;
          out_val_nxt   = product[RECIP_SHIFT +: SAMPLE_BITS];
          out_st_nxt    = STATUS_OK;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      win_ch_r    <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      win_ch_r    <= win_ch_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win_r     <= win_nxt;
    sum_r     <= sum_nxt;
    out_ch_r  <= out_ch_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.result_channel = out_ch_r;
  assign out_s.filtered_value = out_val_r;
  assign out_s.status         = out_st_r;

endmodule

FILE: rtl/trimmed_mean_of_five_samples.sv
// Top level of the five-sample trimmed-mean filter.
// Depends on tmf_pkg, tmf_if, tmf_front, tmf_queue and tmf_back.
//
//   Channel   Dir   Handshake            Payload
//   in_s      in    valid/ready          channel[2:0], sample[9:0]
//   out_s     out   valid/ready          result_channel[2:0], filtered_value[9:0], status
//   cfg       in    cfg_we (no ready)    cfg_wdata[3:0] = channels_present
//
// A sample that does not complete a window is stored by the idle state; a rejected
// request goes straight into the result register. The fifth sample of a window
// starts WINDOW sort passes on the single compare-exchange row, reused for every pass,
// then a sum and a multiply into the result register, which waits for a free output.
// Reset (rst_n, synchronous) empties the window and the queue and sets
// channels_present to 8. A two-entry queue lets the input keep transferring
// while the back end sorts or the result waits for the sink.
module trimmed_mean_of_five_samples (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tmf_pkg::CFG_BITS-1:0] cfg_wdata,
  tmf_in_if.sink                       in_s,
  tmf_out_if.source                    out_s
);
  import tmf_pkg::*;

  tmf_cmd_if front_q ();
  tmf_cmd_if q_back ();

  tmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_s),
    .cmd_s     (front_q.source)
  );

  tmf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_s (front_q.sink),
    .pop_s  (q_back.source)
  );

  tmf_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_s (q_back.sink),
    .out_s (out_s)
  );

endmodule

FILE: dv/tmf_mean_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the five-sample trimmed-mean filter: watches the sample, result
// and config ports, predicts every result and compares it on transfer.
// Depends on tmf_pkg and the channel interfaces in tmf_if.
module tmf_mean_scoreboard
  import tmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  tmf_in_if                   in_mon,
  tmf_out_if                  out_mon,
  output int                  mismatch_count,
  output int                  results_owed
);

  typedef struct packed {
    chan_t   channel;
    sample_t value;
    logic    status;
  } filter_result_t;

  // Shadow of the filter state
  sample_t             win_samples [WINDOW];
  int                  fill_level;
  chan_t               win_channel;
  logic [CFG_BITS-1:0] chans_present;
  filter_result_t      owed_q [$];
  int                  errors = 0;

  // Floor of the mean of the middle three after a descending sort
  function automatic sample_t trimmed_mean();
    sample_t sorted [WINDOW];
    sample_t tmp;
    sum_t    total;
    sorted = win_samples;
    for (int i = 0; i < WINDOW - 1; i++)
      for (int j = 0; j < WINDOW - 1 - i; j++)
        if (sorted[j] < sorted[j+1]) begin
          tmp         = sorted[j];
          sorted[j]   = sorted[j+1];
          sorted[j+1] = tmp;
        end
    total = sum_t'(sorted[MID-1]) + sum_t'(sorted[MID]) + sum_t'(sorted[MID+1]);
    return sample_t'(total / MEAN_COUNT);
  endfunction

  // One accepted sample: reject, collect, or close the window
  function automatic void absorb_sample(chan_t ch, sample_t smp);
    int limit;
    limit = (chans_present > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_present);
    if (int'(ch) >= limit) begin
      // rejected sample leaves the window untouched
      owed_q.push_back(filter_result_t'{channel: ch, value: '0, status: STATUS_RANGE});
      return;
    end
    if (fill_level > 0 && ch != win_channel)
      fill_level = 0;
    win_channel             = ch;
    win_samples[fill_level] = smp;
    fill_level++;
    if (fill_level == WINDOW) begin
      owed_q.push_back(filter_result_t'{channel: ch, value: trimmed_mean(),
                                        status: STATUS_OK});
      fill_level = 0;
    end
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // Inputs are applied before the config write of the same edge
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      fill_level    = 0;
      win_channel   = '0;
      chans_present = CFG_RESET;
      owed_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb_sample(in_mon.channel, in_mon.sample);
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual channel %0d value %0d status %0d",
                   $time, out_mon.result_channel, out_mon.filtered_value, out_mon.status);
          errors++;
        end else begin
          want = owed_q.pop_front();
          check_field("result_channel", want.channel, out_mon.result_channel);
          check_field("filtered_value", want.value, out_mon.filtered_value);
          check_field("status", want.status, out_mon.status);
        end
      end
      if (cfg_we)
        chans_present = cfg_wdata;
    end
    mismatch_count <= errors;
    results_owed   <= owed_q.size();
  end

endmodule

FILE: dv/trimmed_mean_of_five_samples_test.sv
`timescale 1ns / 1ps
// Top of the trimmed-mean filter test: clock, reset, sample stimulus, sink
// back-pressure, config phases, watchdog and verdict.
// Depends on tmf_pkg, tmf_if, the filter RTL and tmf_mean_scoreboard.
module trimmed_mean_of_five_samples_test;
  import tmf_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 100;
  localparam int IDLE_PCT      = 19;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  bit                  steady;
  int                  stall_cycles = 0;
  int                  mismatch_count;
  int                  results_owed;

  // Channel counts per phase; the 8 phase runs with no idling at all
  logic [CFG_BITS-1:0] phase_cfg [8] = '{4'd4, 4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd3, 4'd6};
  sample_t             spread [WINDOW] = '{10'd5, 10'd1000, 10'd2, 10'd999, 10'd3};

  tmf_in_if  in_ch ();
  tmf_out_if out_ch ();

  trimmed_mean_of_five_samples dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_ch),
    .out_s     (out_ch)
  );

  tmf_mean_scoreboard scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result sink back-pressure
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One sample transfer, with random idle cycles in front
  task automatic send_sample(chan_t ch, sample_t smp);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.channel <= ch;
    in_ch.sample  <= smp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending, wait for every owed result, then let the back end go quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel_count(logic [CFG_BITS-1:0] count);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly uniform, with some edge values and some repeats for sort ties
  function automatic sample_t pick_sample(sample_t prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return prev;
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // Bursts of one window on a present channel (any channel when none is present); some cut short, some stray channels
  task automatic run_random_phase(logic [CFG_BITS-1:0] count);
    int      limit;
    int      burst_len;
    int      sent;
    chan_t   burst_ch;
    chan_t   ch;
    sample_t smp;
    limit = (count > MAX_CHANNELS) ? MAX_CHANNELS : int'(count);
    sent  = 0;
    smp   = '0;
    while (sent < PHASE_ITEMS) begin
      burst_ch  = (limit > 0) ? chan_t'($urandom_range(0, limit - 1))
                              : chan_t'($urandom_range(0, 7));
      burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, WINDOW - 1) : WINDOW;
      for (int k = 0; k < burst_len; k++) begin
        ch  = ($urandom_range(0, 99) < 8) ? chan_t'($urandom_range(0, 7)) : burst_ch;
        smp = pick_sample(smp);
        send_sample(ch, smp);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.channel <= '0;
    in_ch.sample  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    steady        <= 1'b0;
    rst_n         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Flat windows at both ends of the sample range, lowest and highest channel
    repeat (WINDOW) send_sample(3'd0, '0);
    repeat (WINDOW) send_sample(3'd7, '1);
    // Large values spread out so the sort has to move them
    foreach (spread[i]) send_sample(3'd3, spread[i]);
    // A lone sample, then a channel change restarts the window
    send_sample(3'd1, 10'd10);
    for (int i = 1; i <= WINDOW; i++) send_sample(3'd2, sample_t'(i * 10 + 20));

    for (int p = 0; p < 8; p++) begin
      write_channel_count(phase_cfg[p]);
      steady <= (phase_cfg[p] == 4'd8);
      if (p == 0) begin
        // Out-of-range channels, one in the middle of a window
        send_sample(3'd5, 10'd77);
        send_sample(3'd2, 10'd100);
        send_sample(3'd2, 10'd200);
        send_sample(3'd6, '1);
        send_sample(3'd2, 10'd300);
        send_sample(3'd2, 10'd400);
        send_sample(3'd2, 10'd500);
      end
      run_random_phase(phase_cfg[p]);
    end

    drain_results();
    if (mismatch_count == 0 && results_owed == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tmf_pkg.sv
rtl/tmf_if.sv
rtl/tmf_front.sv
rtl/tmf_queue.sv
rtl/tmf_back.sv
rtl/trimmed_mean_of_five_samples.sv
dv/tmf_mean_scoreboard.sv
dv/trimmed_mean_of_five_samples_test.sv
